// ===== src/heading_pid_diff_drive_assert.svh =====
// Assertion macros for the heading PID controller.
`ifndef HEADING_PID_DIFF_DRIVE_ASSERT_SVH
`define HEADING_PID_DIFF_DRIVE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define HPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition must never hold.
`define HPD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== src/hpd_pkg.sv =====
package hpd_pkg;

    // Field and datapath widths
    localparam int HEAD_W    = 16;
    localparam int ES_W      = 32;
    localparam int MA_W      = 41;   // multiplier operand A, signed
    localparam int MB_W      = 17;   // multiplier operand B, signed
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ACC_W     = 49;   // P + I + D sum
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;

    // 2*pi in Q3.13
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PER      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SPACE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_D  = 4'd7;

    typedef struct packed {
        logic signed [HEAD_W-1:0] current_heading;
        logic signed [HEAD_W-1:0] target_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               clipped;
    } out_item_t;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_WRAP,     // heading error with seam wrap
        OP_MUL_DT,   // err * dt
        OP_INTEG,    // integrate; err * kp
        OP_MUL_KI,   // acc = P; ki * error_sum
        OP_ADD_I,    // acc += I; kd * (err - last)
        OP_MUL_IP,   // (kd * de) * 1/dt
        OP_ADD_D,    // acc += D
        OP_MUL_WD,   // omega * D
        OP_MIX,      // left/right track terms
        OP_MUL_L,    // left * 1/(2R)
        OP_MUL_R,    // saturate left; right * 1/(2R)
        OP_SAT_R     // saturate right
    } dp_op_t;

    typedef struct packed {
        logic   load_in;
        dp_op_t op;
        logic   load_out;
    } hpd_cmd_t;

endpackage

// ===== src/hpd_datapath.sv =====
module hpd_datapath
    import hpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  hpd_cmd_t             cmd,
    input  in_item_t             s_item,
    output out_item_t            m_item
);

    // Saturation helpers
    function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
        if (x > 50'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (x < -50'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = x[15:0];
        end
    endfunction

    function automatic logic ovf16(input logic signed [49:0] x);
        ovf16 = (x > 50'sd32767) || (x < -50'sd32768);
    endfunction

    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg, fwd_speed_reg;
    logic [15:0]        sample_per_reg, inv_per_reg, wheel_space_reg, inv_wheel_d_reg;

    in_item_t                in_reg;
    logic signed [15:0]      err_reg, last_reg, sl_reg, sr_reg;
    logic signed [ES_W-1:0]  es_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MA_W-1:0]  tl_reg, tr_reg;
    logic                    clip_reg;
    out_item_t               out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg      <= 16'sd256;
            gain_i_reg      <= 16'sd256;
            gain_d_reg      <= 16'sd256;
            sample_per_reg  <= 16'd2048;
            inv_per_reg     <= 16'd512;
            fwd_speed_reg   <= 16'sd0;
            wheel_space_reg <= 16'd1024;
            inv_wheel_d_reg <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_P:      gain_p_reg      <= cfg_data;
                REG_GAIN_I:      gain_i_reg      <= cfg_data;
                REG_GAIN_D:      gain_d_reg      <= cfg_data;
                REG_SAMPLE_PER:  sample_per_reg  <= cfg_data;
                REG_INV_PER:     inv_per_reg     <= cfg_data;
                REG_FWD_SPEED:   fwd_speed_reg   <= cfg_data;
                REG_WHEEL_SPACE: wheel_space_reg <= cfg_data;
                REG_INV_WHEEL_D: inv_wheel_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Heading error, wrapped across the seam and saturated
    logic signed [16:0] diff;
    logic signed [17:0] diff_x, alt, wrap_err;
    logic [17:0]        diff_mag, alt_mag;
    logic signed [15:0] err_sat;

    always_comb begin
        diff     = {in_reg.target_heading[15], in_reg.target_heading}
                 - {in_reg.current_heading[15], in_reg.current_heading};
        diff_x   = {diff[16], diff};
        alt      = diff_x + ((in_reg.target_heading >= in_reg.current_heading)
                             ? -TWO_PI_Q13 : TWO_PI_Q13);
        diff_mag = diff_x[17] ? 18'(-diff_x) : 18'(diff_x);
        alt_mag  = alt[17] ? 18'(-alt) : 18'(alt);
        wrap_err = (alt_mag < diff_mag) ? alt : diff_x;
        err_sat  = sat16({{32{wrap_err[17]}}, wrap_err});
    end

    // Shared multiplier operand select
    logic signed [16:0]       de;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Rounding shifts of the registered product and the sum
    logic signed [PROD_W:0]   prod_x, rnd12, rnd12_sh, rnd8, rnd8_sh;
    logic signed [ACC_W:0]    acc_rnd, acc_sh;
    logic signed [MA_W-1:0]   omega;
    logic signed [33:0]       es_sum;
    logic                     es_ovf;
    logic signed [ES_W-1:0]   es_sat;
    logic signed [PROD_W:0]   base, left_sum, right_sum, left_sh, right_sh;

    always_comb begin
        de = {err_reg[15], err_reg} - {last_reg[15], last_reg};

        // omega from the PID sum
        acc_rnd = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(128);
        acc_sh  = acc_rnd >>> 8;
        omega   = acc_sh[MA_W-1:0];

        // Operand select per step
        case (cmd.op)
            OP_MUL_DT: begin
                mul_a = {{(MA_W-16){err_reg[15]}}, err_reg};
                mul_b = {1'b0, sample_per_reg};
            end
            OP_INTEG: begin
                mul_a = {{(MA_W-16){err_reg[15]}}, err_reg};
                mul_b = {gain_p_reg[15], gain_p_reg};
            end
            OP_MUL_KI: begin
                mul_a = {{(MA_W-ES_W){es_reg[ES_W-1]}}, es_reg};
                mul_b = {gain_i_reg[15], gain_i_reg};
            end
            OP_ADD_I: begin
                mul_a = {{(MA_W-17){de[16]}}, de};
                mul_b = {gain_d_reg[15], gain_d_reg};
            end
            OP_MUL_IP: begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = {1'b0, inv_per_reg};
            end
            OP_MUL_WD: begin
                mul_a = omega;
                mul_b = {1'b0, wheel_space_reg};
            end
            OP_MUL_L: begin
                mul_a = tl_reg;
                mul_b = {1'b0, inv_wheel_d_reg};
            end
            OP_MUL_R: begin
                mul_a = tr_reg;
                mul_b = {1'b0, inv_wheel_d_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        // Round-half-up shifts
        prod_x   = {prod_reg[PROD_W-1], prod_reg};
        rnd12    = prod_x + (PROD_W+1)'(2048);
        rnd12_sh = rnd12 >>> 12;
        rnd8     = prod_x + (PROD_W+1)'(128);
        rnd8_sh  = rnd8 >>> 8;

        // Integral with 32-bit saturation
        es_sum = {{2{es_reg[ES_W-1]}}, es_reg} + rnd12_sh[33:0];
        es_ovf = (es_sum[33:31] != 3'b000) && (es_sum[33:31] != 3'b111);
        if (!es_ovf) begin
            es_sat = es_sum[ES_W-1:0];
        end else if (es_sum[33]) begin
            es_sat = {1'b1, {(ES_W-1){1'b0}}};
        end else begin
            es_sat = {1'b0, {(ES_W-1){1'b1}}};
        end

        // Track terms: 2v*2^17 -/+ omega*D, shifted down by 17 with round-half-up
        base      = {{(PROD_W+1-34){fwd_speed_reg[15]}}, fwd_speed_reg, 18'b0};
        left_sum  = base - prod_x + (PROD_W+1)'(65536);
        right_sum = base + prod_x + (PROD_W+1)'(65536);
        left_sh   = left_sum >>> 17;
        right_sh  = right_sum >>> 17;
    end

    // Controller state that the model keeps between items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            es_reg   <= '0;
            last_reg <= '0;
        end else begin
            if (cmd.op == OP_INTEG) begin
                es_reg <= es_sat;
            end
            if (cmd.op == OP_ADD_I) begin
                last_reg <= err_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (cmd.load_in) begin
            in_reg <= s_item;
        end
        case (cmd.op)
            OP_WRAP: begin
                err_reg  <= err_sat;
                clip_reg <= 1'b0;
            end
            OP_INTEG:  clip_reg <= es_ovf;
            OP_MUL_KI: acc_reg  <= prod_reg[ACC_W-1:0];
            OP_ADD_I:  acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
            OP_ADD_D:  acc_reg  <= acc_reg + rnd8_sh[ACC_W-1:0];
            OP_MIX: begin
                tl_reg <= left_sh[MA_W-1:0];
                tr_reg <= right_sh[MA_W-1:0];
            end
            OP_MUL_R: begin
                sl_reg   <= sat16(rnd8_sh[49:0]);
                clip_reg <= clip_reg | ovf16(rnd8_sh[49:0]);
            end
            OP_SAT_R: begin
                sr_reg   <= sat16(rnd8_sh[49:0]);
                clip_reg <= clip_reg | ovf16(rnd8_sh[49:0]);
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            out_reg.left_speed  <= sl_reg;
            out_reg.right_speed <= sr_reg;
            out_reg.clipped     <= clip_reg;
        end
    end

    assign m_item = out_reg;

endmodule

// ===== src/hpd_ctrl.sv =====
`include "heading_pid_diff_drive_assert.svh"

module hpd_ctrl
    import hpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output hpd_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MUL_DT,
        ST_INTEG,
        ST_MUL_KI,
        ST_ADD_I,
        ST_MUL_IP,
        ST_ADD_D,
        ST_MUL_WD,
        ST_MIX,
        ST_MUL_L,
        ST_MUL_R,
        ST_SAT_R,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Step sequencer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // valid rises on a load and drops once the item is taken
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:   if (s_valid) state_reg <= ST_WRAP;
                ST_WRAP:   state_reg <= ST_MUL_DT;
                ST_MUL_DT: state_reg <= ST_INTEG;
                ST_INTEG:  state_reg <= ST_MUL_KI;
                ST_MUL_KI: state_reg <= ST_ADD_I;
                ST_ADD_I:  state_reg <= ST_MUL_IP;
                ST_MUL_IP: state_reg <= ST_ADD_D;
                ST_ADD_D:  state_reg <= ST_MUL_WD;
                ST_MUL_WD: state_reg <= ST_MIX;
                ST_MIX:    state_reg <= ST_MUL_L;
                ST_MUL_L:  state_reg <= ST_MUL_R;
                ST_MUL_R:  state_reg <= ST_SAT_R;
                ST_SAT_R:  state_reg <= ST_OUT;
                ST_OUT: begin
                    // hand the item to the output register once it is free
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath commands
    always_comb begin
        cmd.load_in  = (state_reg == ST_IDLE) && s_valid;
        cmd.load_out = (state_reg == ST_OUT) && out_free;
        case (state_reg)
            ST_WRAP:   cmd.op = OP_WRAP;
            ST_MUL_DT: cmd.op = OP_MUL_DT;
            ST_INTEG:  cmd.op = OP_INTEG;
            ST_MUL_KI: cmd.op = OP_MUL_KI;
            ST_ADD_I:  cmd.op = OP_ADD_I;
            ST_MUL_IP: cmd.op = OP_MUL_IP;
            ST_ADD_D:  cmd.op = OP_ADD_D;
            ST_MUL_WD: cmd.op = OP_MUL_WD;
            ST_MIX:    cmd.op = OP_MIX;
            ST_MUL_L:  cmd.op = OP_MUL_L;
            ST_MUL_R:  cmd.op = OP_MUL_R;
            ST_SAT_R:  cmd.op = OP_SAT_R;
            default:   cmd.op = OP_IDLE;
        endcase
    end

    // A waiting result is never overwritten
    `HPD_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.load_out && m_valid_reg && !m_ready)
    // Loading the output register raises valid
    `HPD_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load_out, m_valid_reg)
    // An accepted item starts the wrap step at once
    `HPD_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, !s_ready && cmd.op == OP_WRAP)
    // While ready, the datapath does nothing to the running state
    `HPD_ASSERT_IMPL(a_ready_quiet, aclk, aresetn, s_ready, cmd.op == OP_IDLE && !cmd.load_out)

endmodule

// ===== src/heading_pid_diff_drive.sv =====
// Heading PID controller for a differential-drive robot.
// Input channel s_*: one item carries the current and target heading (Q3.13).
// Result channel m_*: left and right wheel speeds (Q8.8, saturated) plus a
// clipped flag, one result item per input item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..7:
// gains P/I/D, dt, 1/dt, forward speed, wheel spacing, 1/(2R)); other
// indexes are ignored. Write only while no item is in flight.
// m_valid rises once the sequencer has run through its steps and loaded the
// output register. All eight products go through a single 41x17 multiplier,
// one per step of the sequencer, each registered.
// s_ready is high only while the sequencer is idle.
// When the receiver stalls, the result waits in the output register; the
// next item is still accepted and computed, and holds in its last step until
// the output register frees.
// Reset (aresetn low, synchronous) clears the integral and the previous
// error, restores the register defaults and drops m_valid.
module heading_pid_diff_drive
    import hpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    hpd_cmd_t cmd;

    // Sequencer
    hpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Arithmetic, state and configuration
    hpd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .s_item    (s_item),
        .m_item    (m_item)
    );

endmodule
